### sv/cchd_pkg.sv
// Shared types and constants for the capped cylinder hit distance block.
// Used by every module of the block; depends on nothing.
package cchd_pkg;

    localparam int DEFAULT_FRAC_BITS = 16;
    localparam int DIV_W = 32;

    localparam logic signed [31:0] DIST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] body_distance;
        logic        [30:0] radius;
        logic signed [31:0] height;
    } req_t;

    typedef struct packed {
        logic signed [31:0] hit_distance;
        logic               no_hit;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_z;
        logic signed [31:0] body_distance;
        logic        [30:0] radius;
        logic [DIV_W-1:0]   divisor;
        logic               top_neg;
        logic               bot_neg;
        logic               dir_flat;
        logic               cap_test;
    } ride_t;

endpackage

### sv/cylinder_cap_hit_distance.sv
// Top level of the capped cylinder hit distance block: front stages, divider cell row, back stages.
// Depends on cchd_pkg, cchd_prep, cchd_cell and cchd_post.
//
//   channel   signals                      direction
//   request   req_valid, req_stall, req    in
//   result    rsp_valid, rsp_stall, rsp    out
//
// One request is taken every cycle while no result is held; each result passes the front stages,
// the row of divider cells (one quotient bit per cell) and the back stages.
// Reset clears only the valid bits of the pipeline.
// While a result is held by rsp_stall the whole pipeline holds and req_stall is raised.
module cylinder_cap_hit_distance #(
    parameter int FRAC_BITS = cchd_pkg::DEFAULT_FRAC_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  cchd_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output cchd_pkg::rsp_t  rsp
);

    localparam int NUM_W = 32 + FRAC_BITS;

    logic                       en;
    logic                       c_valid [NUM_W+1];
    cchd_pkg::ride_t            c_ride [NUM_W+1];
    logic [NUM_W-1:0]           c_num [NUM_W+1][2];
    logic [cchd_pkg::DIV_W-1:0] c_rem [NUM_W+1][2];
    logic [NUM_W-1:0]           c_quo [NUM_W+1][2];

    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    cchd_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_valid (req_valid),
        .req       (req),
        .valid     (c_valid[0]),
        .ride      (c_ride[0]),
        .top_num   (c_num[0][0]),
        .bot_num   (c_num[0][1])
    );

    assign c_rem[0][0] = '0;
    assign c_rem[0][1] = '0;
    assign c_quo[0][0] = '0;
    assign c_quo[0][1] = '0;

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_cell
        cchd_cell #(.NUM_W(NUM_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (c_valid[i]),
            .ride_in   (c_ride[i]),
            .num_in    (c_num[i]),
            .rem_in    (c_rem[i]),
            .quo_in    (c_quo[i]),
            .valid_out (c_valid[i+1]),
            .ride_out  (c_ride[i+1]),
            .num_out   (c_num[i+1]),
            .rem_out   (c_rem[i+1]),
            .quo_out   (c_quo[i+1])
        );
    end

    cchd_post #(.FRAC_BITS(FRAC_BITS)) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (c_valid[NUM_W]),
        .ride_in   (c_ride[NUM_W]),
        .quo_in    (c_quo[NUM_W]),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    a_miss_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.no_hit |-> rsp.hit_distance == cchd_pkg::DIST_MAX)
        else $error("A missed cap test must report the maximum distance.");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("The pipeline must take requests while no result is held.");

    a_held_stays: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && req_stall == rsp_stall)
        else $error("A held result must stay and keep the pipeline frozen.");

endmodule

### sv/cchd_prep.sv
// Front stages: request register, axis product and cap-plane numerators.
// Depends on cchd_pkg; feeds the first divider cell.
module cchd_prep #(
    parameter int FRAC_BITS = cchd_pkg::DEFAULT_FRAC_BITS,
    localparam int NUM_W = 32 + FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 req_valid,
    input  cchd_pkg::req_t       req,
    output logic                 valid,
    output cchd_pkg::ride_t      ride,
    output logic [NUM_W-1:0]     top_num,
    output logic [NUM_W-1:0]     bot_num
);

    logic                  s1_valid_reg;
    cchd_pkg::req_t        s1_req_reg;
    logic                  s2_valid_reg;
    cchd_pkg::req_t        s2_req_reg;
    logic signed [63:0]    prod_reg;
    logic signed [63:0]    prod_next;
    logic signed [32:0]    top_diff_reg;
    logic signed [32:0]    top_diff_next;
    logic signed [32:0]    bot_diff_reg;
    logic signed [32:0]    bot_diff_next;
    logic                  s3_valid_reg;
    cchd_pkg::ride_t       ride_reg;
    cchd_pkg::ride_t       ride_next;
    logic [NUM_W-1:0]      top_num_reg;
    logic [NUM_W-1:0]      top_num_next;
    logic [NUM_W-1:0]      bot_num_reg;
    logic [NUM_W-1:0]      bot_num_next;
    logic signed [64:0]    hy;
    logic signed [64:0]    hmax;
    logic                  in_range;
    logic [32:0]           top_abs;
    logic [32:0]           bot_abs;
    logic [32:0]           dy_abs;

    always_comb
    begin
        prod_next     = s1_req_reg.dir_y * s1_req_reg.body_distance;
        top_diff_next = 33'(s1_req_reg.height) - 33'(s1_req_reg.origin_y);
        bot_diff_next = 33'sd0 - 33'(s1_req_reg.origin_y);
    end

    always_comb
    begin
        hy     = (65'(s2_req_reg.origin_y) <<< FRAC_BITS) + 65'(prod_reg);
        hmax   = 65'(s2_req_reg.height) <<< FRAC_BITS;
        in_range = (hy >= 65'sd0) && (hy <= hmax);
        top_abs = top_diff_reg[32] ? 33'(-top_diff_reg) : 33'(top_diff_reg);
        bot_abs = bot_diff_reg[32] ? 33'(-bot_diff_reg) : 33'(bot_diff_reg);
        dy_abs  = s2_req_reg.dir_y[31] ? 33'(-33'(s2_req_reg.dir_y))
                                       : 33'(s2_req_reg.dir_y);
        top_num_next = {top_abs[31:0], {FRAC_BITS{1'b0}}};
        bot_num_next = {bot_abs[31:0], {FRAC_BITS{1'b0}}};
        ride_next.origin_x      = s2_req_reg.origin_x;
        ride_next.origin_z      = s2_req_reg.origin_z;
        ride_next.dir_x         = s2_req_reg.dir_x;
        ride_next.dir_z         = s2_req_reg.dir_z;
        ride_next.body_distance = s2_req_reg.body_distance;
        ride_next.radius        = s2_req_reg.radius;
        ride_next.divisor       = dy_abs[31:0];
        ride_next.top_neg       = top_diff_reg[32] ^ s2_req_reg.dir_y[31];
        ride_next.bot_neg       = bot_diff_reg[32] ^ s2_req_reg.dir_y[31];
        ride_next.dir_flat      = (s2_req_reg.dir_y == 32'sd0);
        ride_next.cap_test      = !s2_req_reg.body_distance[31]
                                  && (s2_req_reg.height > 32'sd0) && !in_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= req_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_req_reg   <= req;
            s2_req_reg   <= s1_req_reg;
            prod_reg     <= prod_next;
            top_diff_reg <= top_diff_next;
            bot_diff_reg <= bot_diff_next;
            ride_reg     <= ride_next;
            top_num_reg  <= top_num_next;
            bot_num_reg  <= bot_num_next;
        end
    end

    assign valid   = s3_valid_reg;
    assign ride    = ride_reg;
    assign top_num = top_num_reg;
    assign bot_num = bot_num_reg;

endmodule

### sv/cchd_cell.sv
// One divider cell: retires one quotient bit for both cap planes.
// Depends on cchd_pkg; chained by the top level.
module cchd_cell #(
    parameter int NUM_W = 32 + cchd_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid_in,
    input  cchd_pkg::ride_t            ride_in,
    input  logic [NUM_W-1:0]           num_in [2],
    input  logic [cchd_pkg::DIV_W-1:0] rem_in [2],
    input  logic [NUM_W-1:0]           quo_in [2],
    output logic                       valid_out,
    output cchd_pkg::ride_t            ride_out,
    output logic [NUM_W-1:0]           num_out [2],
    output logic [cchd_pkg::DIV_W-1:0] rem_out [2],
    output logic [NUM_W-1:0]           quo_out [2]
);

    logic                       valid_reg;
    cchd_pkg::ride_t            ride_reg;
    logic [NUM_W-1:0]           num_reg [2];
    logic [NUM_W-1:0]           num_next [2];
    logic [cchd_pkg::DIV_W-1:0] rem_reg [2];
    logic [cchd_pkg::DIV_W-1:0] rem_next [2];
    logic [NUM_W-1:0]           quo_reg [2];
    logic [NUM_W-1:0]           quo_next [2];
    logic [cchd_pkg::DIV_W:0]   trial [2];
    logic                       fits [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            trial[l] = {rem_in[l], num_in[l][NUM_W-1]};
            fits[l]  = trial[l] >= {1'b0, ride_in.divisor};
            rem_next[l] = fits[l] ? cchd_pkg::DIV_W'(trial[l] - {1'b0, ride_in.divisor})
                                  : trial[l][cchd_pkg::DIV_W-1:0];
            num_next[l] = {num_in[l][NUM_W-2:0], 1'b0};
            quo_next[l] = {quo_in[l][NUM_W-2:0], fits[l]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ride_reg <= ride_in;
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign valid_out = valid_reg;
    assign ride_out  = ride_reg;
    assign num_out   = num_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;

endmodule

### sv/cchd_post.sv
// Back stages: saturate the cap distances, radius test, cap choice, result register.
// Depends on cchd_pkg; takes the last divider cell's output.
module cchd_post #(
    parameter int FRAC_BITS = cchd_pkg::DEFAULT_FRAC_BITS,
    localparam int NUM_W = 32 + FRAC_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  cchd_pkg::ride_t  ride_in,
    input  logic [NUM_W-1:0] quo_in [2],
    output logic             rsp_valid,
    output cchd_pkg::rsp_t   rsp
);

    localparam logic [NUM_W-1:0] QPOS = NUM_W'(33'h0_7FFF_FFFF);
    localparam logic [NUM_W-1:0] QNEG = NUM_W'(33'h0_8000_0000);
    localparam logic signed [64:0] BIAS = (65'sd1 <<< FRAC_BITS) - 65'sd1;

    logic [5:0]            vld_reg;
    logic                  out_valid_reg;
    cchd_pkg::rsp_t        rsp_reg;
    cchd_pkg::rsp_t        rsp_next;
    cchd_pkg::ride_t       ride_reg [6];
    logic signed [31:0]    d_next [2];
    logic signed [31:0]    d_reg [6][2];
    logic signed [63:0]    prod_next [2][2];
    logic signed [63:0]    prod_reg [2][2];
    logic signed [64:0]    sum_next [2][2];
    logic signed [64:0]    sum_reg [2][2];
    logic signed [64:0]    px_next [2][2];
    logic signed [64:0]    px_reg [2][2];
    logic signed [64:0]    mag_full [2][2];
    logic                  far_next [2][2];
    logic                  far_reg [2][2];
    logic                  far2_reg [2][2];
    logic [30:0]           mag_next [2][2];
    logic [30:0]           mag_reg [2][2];
    logic [61:0]           sq_next [2][2];
    logic [61:0]           sq_reg [2][2];
    logic [61:0]           rr_next;
    logic [61:0]           rr_reg;
    logic                  hit [2];
    logic                  neg;
    logic signed [31:0]    dirv;
    logic signed [31:0]    orgv;

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            neg = (c == 0) ? ride_in.top_neg : ride_in.bot_neg;
            if (neg)
            begin
                d_next[c] = (quo_in[c] > QNEG) ? cchd_pkg::DIST_MIN
                                               : 32'sd0 - $signed(quo_in[c][31:0]);
            end
            else
            begin
                d_next[c] = (quo_in[c] > QPOS) ? cchd_pkg::DIST_MAX
                                               : $signed(quo_in[c][31:0]);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            for (int a = 0; a < 2; a++)
            begin
                dirv = (a == 0) ? ride_reg[0].dir_x : ride_reg[0].dir_z;
                orgv = (a == 0) ? ride_reg[1].origin_x : ride_reg[1].origin_z;
                prod_next[c][a] = dirv * d_reg[0][c];
                sum_next[c][a]  = (65'(orgv) <<< FRAC_BITS) + 65'(prod_reg[c][a]);
                px_next[c][a]   = (sum_reg[c][a] + (sum_reg[c][a][64] ? BIAS : 65'sd0))
                                  >>> FRAC_BITS;
                mag_full[c][a]  = px_reg[c][a][64] ? -px_reg[c][a] : px_reg[c][a];
                far_next[c][a]  = mag_full[c][a] > 65'(ride_reg[3].radius);
                mag_next[c][a]  = mag_full[c][a][30:0];
                sq_next[c][a]   = 62'(mag_reg[c][a]) * 62'(mag_reg[c][a]);
            end
        end
        rr_next = 62'(ride_reg[4].radius) * 62'(ride_reg[4].radius);
    end

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            hit[c] = !far2_reg[c][0] && !far2_reg[c][1] && !ride_reg[5].dir_flat
                     && ((63'(sq_reg[c][0]) + 63'(sq_reg[c][1])) <= 63'(rr_reg));
        end
        rsp_next.hit_distance = ride_reg[5].body_distance;
        rsp_next.no_hit       = 1'b0;
        if (ride_reg[5].cap_test)
        begin
            priority if (hit[0] && hit[1])
            begin
                rsp_next.hit_distance = (d_reg[5][0] > d_reg[5][1]) ? d_reg[5][1]
                                                                    : d_reg[5][0];
            end
            else if (hit[0])
            begin
                rsp_next.hit_distance = d_reg[5][0];
            end
            else if (hit[1])
            begin
                rsp_next.hit_distance = d_reg[5][1];
            end
            else
            begin
                rsp_next.hit_distance = cchd_pkg::DIST_MAX;
                rsp_next.no_hit       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[4:0], valid_in};
            out_valid_reg <= vld_reg[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ride_reg[0] <= ride_in;
            d_reg[0]    <= d_next;
            for (int s = 1; s < 6; s++)
            begin
                ride_reg[s] <= ride_reg[s-1];
                d_reg[s]    <= d_reg[s-1];
            end
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
            px_reg   <= px_next;
            far_reg  <= far_next;
            far2_reg <= far_reg;
            mag_reg  <= mag_next;
            sq_reg   <= sq_next;
            rr_reg   <= rr_next;
            rsp_reg  <= rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule
